[src/h264nal_pkg.sv]
// Shared types and constants of the H.264 Annex B NAL unit splitter.
package h264nal_pkg;

    localparam int LEN_BITS_DEF = 24;
    localparam int QUEUE_AW_DEF = 2;

    localparam int          CFG_W         = 24;
    localparam int          OUT_LEN_W     = 24;
    localparam logic [23:0] MAX_LEN_RESET = 24'd100000;
    localparam logic [23:0] OUT_LEN_MAX   = 24'hFF_FFFF;

    localparam logic [2:0] SC_LEN3 = 3'd3;
    localparam logic [2:0] SC_LEN4 = 3'd4;

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;

    typedef struct packed {
        logic [31:0] unit_index;
        logic [31:0] start_offset;
        logic [2:0]  code_len;
        logic [7:0]  hdr_byte;
        logic        final_rec;
    } t_rec_hdr;

    localparam int REC_HDR_W = $bits(t_rec_hdr);

endpackage

[src/h264nal_front.sv]
// Start code detection and per-unit bookkeeping, one stream byte per beat.
module h264nal_front
    import h264nal_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_end_of_stream,
    input  logic                          i_full,
    output logic                          o_push,
    output logic [REC_HDR_W+LEN_BITS-1:0] o_rec
);

    logic [1:0]          r_zero_run,   n_zero_run;
    logic                r_in_unit,    n_in_unit;
    logic                r_hdr_pending, n_hdr_pending;
    logic [7:0]          r_hdr_byte,   n_hdr_byte;
    logic [31:0]         r_pos,        n_pos;
    logic [31:0]         r_unit_start, n_unit_start;
    logic [2:0]          r_code_len,   n_code_len;
    logic [LEN_BITS-1:0] r_unit_len,   n_unit_len;
    logic [31:0]         r_count,      n_count;

    logic                accept;
    logic                code_hit;
    logic [2:0]          code;
    logic                rec_ok;
    t_rec_hdr            rec_hdr;
    logic [LEN_BITS-1:0] rec_len;

    function automatic logic [LEN_BITS-1:0] f_sat_add(
        input logic [LEN_BITS-1:0] a,
        input logic [2:0]          b
    );
        logic [LEN_BITS:0] s;
        s = {1'b0, a} + (LEN_BITS+1)'(b);
        return s[LEN_BITS] ? {LEN_BITS{1'b1}} : s[LEN_BITS-1:0];
    endfunction

    assign accept   = i_valid && !i_full;
    assign code_hit = (i_data_byte == BYTE_ONE) && r_zero_run[1];
    assign code     = (r_zero_run == 2'd3) ? SC_LEN4 : SC_LEN3;

    always_comb begin
        n_zero_run    = r_zero_run;
        n_in_unit     = r_in_unit;
        n_hdr_pending = 1'b0;
        n_hdr_byte    = r_hdr_pending ? i_data_byte : r_hdr_byte;
        n_pos         = r_pos + 32'd1;
        n_unit_start  = r_unit_start;
        n_code_len    = r_code_len;
        n_unit_len    = r_unit_len;
        n_count       = r_count;
        rec_ok        = 1'b0;
        rec_hdr       = '{unit_index: r_count, start_offset: r_unit_start,
                          code_len: r_code_len, hdr_byte: n_hdr_byte,
                          final_rec: i_end_of_stream};
        rec_len       = r_unit_len;

        if (i_data_byte == BYTE_ZERO) begin
            if (r_zero_run == 2'd3) begin
                if (r_in_unit) begin
                    n_unit_len = f_sat_add(r_unit_len, 3'd1);
                end
            end else begin
                n_zero_run = r_zero_run + 2'd1;
            end
        end else if (code_hit) begin
            if (r_in_unit) begin
                rec_ok  = 1'b1;
                n_count = r_count + 32'd1;
            end
            n_in_unit     = 1'b1;
            n_unit_start  = r_pos - ((code == SC_LEN4) ? 32'd3 : 32'd2);
            n_code_len    = code;
            n_unit_len    = '0;
            n_hdr_pending = 1'b1;
            n_hdr_byte    = BYTE_ZERO;
            n_zero_run    = 2'd0;
        end else begin
            if (r_in_unit) begin
                n_unit_len = f_sat_add(r_unit_len, {1'b0, r_zero_run} + 3'd1);
            end
            n_zero_run = 2'd0;
        end

        if (i_end_of_stream && !rec_ok && n_in_unit) begin
            rec_ok  = 1'b1;
            rec_hdr = '{unit_index: n_count, start_offset: n_unit_start,
                        code_len: n_code_len, hdr_byte: n_hdr_byte,
                        final_rec: 1'b1};
            rec_len = f_sat_add(n_unit_len, {1'b0, n_zero_run});
        end
    end

    assign o_push = accept && rec_ok;
    assign o_rec  = {rec_hdr, rec_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_end_of_stream)) begin
            r_zero_run    <= 2'd0;
            r_in_unit     <= 1'b0;
            r_hdr_pending <= 1'b0;
            r_hdr_byte    <= BYTE_ZERO;
            r_pos         <= '0;
            r_unit_start  <= '0;
            r_code_len    <= SC_LEN3;
            r_unit_len    <= '0;
            r_count       <= '0;
        end else if (accept) begin
            r_zero_run    <= n_zero_run;
            r_in_unit     <= n_in_unit;
            r_hdr_pending <= n_hdr_pending;
            r_hdr_byte    <= n_hdr_byte;
            r_pos         <= n_pos;
            r_unit_start  <= n_unit_start;
            r_code_len    <= n_code_len;
            r_unit_len    <= n_unit_len;
            r_count       <= n_count;
        end
    end

endmodule

[src/h264nal_fifo.sv]
// Short record queue between the byte front end and the output stage.
module h264nal_fifo
    import h264nal_pkg::*;
#(
    parameter int WIDTH = REC_HDR_W + LEN_BITS_DEF,
    parameter int AW    = QUEUE_AW_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = 1 << AW;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + (AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[src/h264nal_back.sv]
// Output stage: limit register, header split, length clamp and oversize flag.
module h264nal_back
    import h264nal_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic                          i_q_valid,
    input  logic [REC_HDR_W+LEN_BITS-1:0] i_q_data,
    output logic                          o_q_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [31:0]                   o_unit_index,
    output logic [31:0]                   o_start_offset,
    output logic [2:0]                    o_start_code_len,
    output logic                          o_fzero_bit,
    output logic [1:0]                    o_ref_idc,
    output logic [4:0]                    o_unit_type,
    output logic [OUT_LEN_W-1:0]          o_payload_len,
    output logic                          o_oversize,
    output logic                          o_stream_final
);

    localparam int CMP_W = (LEN_BITS > OUT_LEN_W) ? LEN_BITS : OUT_LEN_W;

    logic [CFG_W-1:0]    r_max_len;
    logic                r_valid;
    t_rec_hdr            r_hdr;
    logic [OUT_LEN_W-1:0] r_plen;
    logic                r_over;

    t_rec_hdr            q_hdr;
    logic [LEN_BITS-1:0] q_len;
    logic [CMP_W-1:0]    len_x;
    logic                load;

    assign q_hdr = t_rec_hdr'(i_q_data[REC_HDR_W+LEN_BITS-1:LEN_BITS]);
    assign q_len = i_q_data[LEN_BITS-1:0];
    assign len_x = CMP_W'(q_len);
    assign load  = i_q_valid && (!r_valid || !i_out_stall);
    assign o_q_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_wr) begin
            r_max_len <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_hdr  <= q_hdr;
            r_plen <= (len_x > CMP_W'(OUT_LEN_MAX)) ? OUT_LEN_MAX : len_x[OUT_LEN_W-1:0];
            r_over <= (len_x > CMP_W'(r_max_len));
        end
    end

    assign o_out_valid      = r_valid;
    assign o_unit_index     = r_hdr.unit_index;
    assign o_start_offset   = r_hdr.start_offset;
    assign o_start_code_len = r_hdr.code_len;
    assign o_fzero_bit      = r_hdr.hdr_byte[7];
    assign o_ref_idc        = r_hdr.hdr_byte[6:5];
    assign o_unit_type      = r_hdr.hdr_byte[4:0];
    assign o_payload_len    = r_plen;
    assign o_oversize       = r_over;
    assign o_stream_final   = r_hdr.final_rec;

endmodule

[src/h264_nal_unit_splitter.sv]
// Top level of the H.264 Annex B NAL unit splitter.
//
//  channel   direction  handshake               payload
//  in        sink       i_in_valid/o_in_stall   i_data_byte, i_end_of_stream
//  out       source     o_out_valid/i_out_stall unit record fields
//  cfg       sink       i_cfg_valid/o_cfg_ready i_cfg_data (max_payload_len)
//
// One byte per cycle while o_in_stall is low; the record of a unit is written into
// the queue with the byte that ends it, then loaded into the output register. The
// front end sets throughput with its byte update. Reset is synchronous and clears
// all stream state; the limit returns to 100000. An output stall fills the record
// queue and raises o_in_stall; every byte then waits until the queue frees a slot.
module h264_nal_unit_splitter
    import h264nal_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEF,
    parameter int QUEUE_AW = QUEUE_AW_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_end_of_stream,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [31:0]          o_unit_index,
    output logic [31:0]          o_start_offset,
    output logic [2:0]           o_start_code_len,
    output logic                 o_fzero_bit,
    output logic [1:0]           o_ref_idc,
    output logic [4:0]           o_unit_type,
    output logic [OUT_LEN_W-1:0] o_payload_len,
    output logic                 o_oversize,
    output logic                 o_stream_final
);

    localparam int REC_W = REC_HDR_W + LEN_BITS;

    logic             q_full;
    logic             q_push;
    logic [REC_W-1:0] q_wdata;
    logic             q_valid;
    logic [REC_W-1:0] q_rdata;
    logic             q_pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;

    h264nal_front #(
        .LEN_BITS(LEN_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .i_data_byte    (i_data_byte),
        .i_end_of_stream(i_end_of_stream),
        .i_full         (q_full),
        .o_push         (q_push),
        .o_rec          (q_wdata)
    );

    h264nal_fifo #(
        .WIDTH(REC_W),
        .AW   (QUEUE_AW)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_wdata),
        .i_pop  (q_pop),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_data (q_rdata)
    );

    h264nal_back #(
        .LEN_BITS(LEN_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr        (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_q_valid       (q_valid),
        .i_q_data        (q_rdata),
        .o_q_pop         (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_unit_index    (o_unit_index),
        .o_start_offset  (o_start_offset),
        .o_start_code_len(o_start_code_len),
        .o_fzero_bit     (o_fzero_bit),
        .o_ref_idc       (o_ref_idc),
        .o_unit_type     (o_unit_type),
        .o_payload_len   (o_payload_len),
        .o_oversize      (o_oversize),
        .o_stream_final  (o_stream_final)
    );

endmodule

[src/h264nal_checker.sv]
// Port-level checks of the NAL unit splitter, bound to its top level.
module h264nal_checker
    import h264nal_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [31:0]          o_unit_index,
    input logic [31:0]          o_start_offset,
    input logic [2:0]           o_start_code_len,
    input logic                 o_fzero_bit,
    input logic [1:0]           o_ref_idc,
    input logic [4:0]           o_unit_type,
    input logic [OUT_LEN_W-1:0] o_payload_len,
    input logic                 o_oversize,
    input logic                 o_stream_final
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_unit_index)
            && $stable(o_start_offset) && $stable(o_payload_len)
            && $stable(o_stream_final))
        else $error("output beat changed under stall");

    a_code_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_start_code_len == SC_LEN3) || (o_start_code_len == SC_LEN4))
        else $error("start code length is neither 3 nor 4");

    a_empty_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_payload_len == '0) |-> !o_oversize && !o_fzero_bit
            && (o_ref_idc == 2'd0) && (o_unit_type == 5'd0))
        else $error("empty unit reports header bits or oversize");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall && !o_out_valid)
        else $error("stall or output valid after reset");

endmodule

bind h264_nal_unit_splitter h264nal_checker u_checker (.*);

[tb/sv/h264_nal_unit_splitter_test.sv]
// Self-checking testbench for the H.264 Annex B NAL unit splitter.
module h264_nal_unit_splitter_test
    import h264nal_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0]          unit_index;
        logic [31:0]          start_offset;
        logic [2:0]           code_len;
        logic                 forbidden;
        logic [1:0]           ref_idc;
        logic [4:0]           unit_type;
        logic [OUT_LEN_W-1:0] payload_len;
        logic                 oversize;
        logic                 stream_final;
    } t_unit_rec;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
        logic       typed;
        t_unit_rec  unit;
    } t_dir_row;

    localparam t_unit_rec NO_UNIT = '0;
    localparam int N_DIRECTED = 24;
    localparam int N_PHASES = 7;
    localparam int PHASE_BYTES = 60;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [7:0] in_byte = '0;
    logic in_eos = 1'b0;
    logic in_typed = 1'b0;
    t_unit_rec in_typed_unit = '0;
    logic cfg_valid = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic out_stall = 1'b0;

    logic o_in_stall, o_cfg_ready, o_out_valid;
    logic [31:0] o_unit_index, o_start_offset;
    logic [2:0] o_start_code_len;
    logic o_fzero_bit, o_oversize, o_stream_final;
    logic [1:0] o_ref_idc;
    logic [4:0] o_unit_type;
    logic [OUT_LEN_W-1:0] o_payload_len;

    int gap_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    t_unit_rec pending_units[$];
    logic [7:0] stream_bytes[$];
    t_dir_row directed_rows[N_DIRECTED];
    logic [CFG_W-1:0] phase_limits[N_PHASES];

    logic pred_valid;
    t_unit_rec pred_unit, seen_unit;

    // splitter state mirror
    logic [CFG_W-1:0] payload_limit = MAX_LEN_RESET;
    int sp_zeros = 0;
    logic sp_in_unit = 1'b0;
    logic sp_hdr_pending = 1'b0;
    logic [7:0] sp_hdr = '0;
    logic [31:0] sp_pos = '0;
    logic [31:0] sp_start = '0;
    logic [2:0] sp_code = SC_LEN3;
    logic [OUT_LEN_W-1:0] sp_len = '0;
    logic [31:0] sp_count = '0;

    h264_nal_unit_splitter dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (in_byte),
        .i_end_of_stream  (in_eos),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_unit_index     (o_unit_index),
        .o_start_offset   (o_start_offset),
        .o_start_code_len (o_start_code_len),
        .o_fzero_bit      (o_fzero_bit),
        .o_ref_idc        (o_ref_idc),
        .o_unit_type      (o_unit_type),
        .o_payload_len    (o_payload_len),
        .o_oversize       (o_oversize),
        .o_stream_final   (o_stream_final)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_unit_rec typed_unit(input logic [31:0] idx, input logic [31:0] offs,
                                             input logic [2:0] code, input logic [7:0] hdr,
                                             input logic [OUT_LEN_W-1:0] plen, input logic fin);
        t_unit_rec u;
        u = '{idx, offs, code, hdr[7], hdr[6:5], hdr[4:0], plen, 1'b0, fin};
        return u;
    endfunction

    function automatic logic [OUT_LEN_W-1:0] len_plus(input logic [OUT_LEN_W-1:0] len,
                                                     input int inc);
        logic [OUT_LEN_W:0] s;
        s = {1'b0, len} + inc[OUT_LEN_W:0];
        return (s > {1'b0, OUT_LEN_MAX}) ? OUT_LEN_MAX : s[OUT_LEN_W-1:0];
    endfunction

    function automatic t_unit_rec unit_record(input logic [OUT_LEN_W-1:0] len, input logic fin);
        t_unit_rec u;
        u = '{sp_count, sp_start, sp_code, sp_hdr[7], sp_hdr[6:5], sp_hdr[4:0], len,
              len > payload_limit, fin};
        return u;
    endfunction

    task automatic split_byte(input logic [7:0] b, input logic eos,
                              output logic got, output t_unit_rec u);
        logic [31:0] pos;
        logic [2:0] code;
        pos = sp_pos;
        got = 1'b0;
        u = NO_UNIT;
        if (sp_hdr_pending) begin
            sp_hdr = b;
            sp_hdr_pending = 1'b0;
        end
        if (b == BYTE_ZERO) begin
            if (sp_zeros == 3) begin
                if (sp_in_unit) sp_len = len_plus(sp_len, 1);
            end else begin
                sp_zeros++;
            end
        end else if (b == BYTE_ONE && sp_zeros >= 2) begin
            code = (sp_zeros == 3) ? SC_LEN4 : SC_LEN3;
            if (sp_in_unit) begin
                u = unit_record(sp_len, eos);
                sp_count++;
                got = 1'b1;
            end
            sp_in_unit = 1'b1;
            sp_start = pos - {29'd0, code} + 32'd1;
            sp_code = code;
            sp_len = '0;
            sp_hdr_pending = 1'b1;
            sp_hdr = '0;
            sp_zeros = 0;
        end else begin
            if (sp_in_unit) sp_len = len_plus(sp_len, sp_zeros + 1);
            sp_zeros = 0;
        end
        sp_pos = pos + 32'd1;
        if (eos) begin
            if (!got && sp_in_unit) begin
                u = unit_record(len_plus(sp_len, sp_zeros), 1'b1);
                got = 1'b1;
            end
            sp_zeros = 0;
            sp_in_unit = 1'b0;
            sp_hdr_pending = 1'b0;
            sp_hdr = '0;
            sp_pos = '0;
            sp_start = '0;
            sp_code = SC_LEN3;
            sp_len = '0;
            sp_count = '0;
        end
    endtask

    task automatic check_unit(input t_unit_rec seen);
        t_unit_rec want;
        if (pending_units.size() == 0) begin
            $error("unexpected unit record: unit_index %0d", seen.unit_index);
            mismatches++;
        end else begin
            want = pending_units.pop_front();
            if (seen.unit_index !== want.unit_index) begin
                $error("unit_index: expected %0d, got %0d", want.unit_index, seen.unit_index);
                mismatches++;
            end
            if (seen.start_offset !== want.start_offset) begin
                $error("start_offset: expected %0d, got %0d", want.start_offset,
                       seen.start_offset);
                mismatches++;
            end
            if (seen.code_len !== want.code_len) begin
                $error("start_code_len: expected %0d, got %0d", want.code_len, seen.code_len);
                mismatches++;
            end
            if (seen.forbidden !== want.forbidden) begin
                $error("fzero_bit: expected %0d, got %0d", want.forbidden, seen.forbidden);
                mismatches++;
            end
            if (seen.ref_idc !== want.ref_idc) begin
                $error("ref_idc: expected %0d, got %0d", want.ref_idc, seen.ref_idc);
                mismatches++;
            end
            if (seen.unit_type !== want.unit_type) begin
                $error("unit_type: expected %0d, got %0d", want.unit_type, seen.unit_type);
                mismatches++;
            end
            if (seen.payload_len !== want.payload_len) begin
                $error("payload_len: expected %0d, got %0d", want.payload_len,
                       seen.payload_len);
                mismatches++;
            end
            if (seen.oversize !== want.oversize) begin
                $error("oversize: expected %0d, got %0d", want.oversize, seen.oversize);
                mismatches++;
            end
            if (seen.stream_final !== want.stream_final) begin
                $error("stream_final: expected %0d, got %0d", want.stream_final,
                       seen.stream_final);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && !o_in_stall) begin
                split_byte(in_byte, in_eos, pred_valid, pred_unit);
                if (in_typed) pending_units.push_back(in_typed_unit);
                else if (pred_valid) pending_units.push_back(pred_unit);
            end
            if (o_out_valid && !out_stall) begin
                seen_unit = '{o_unit_index, o_start_offset, o_start_code_len, o_fzero_bit,
                              o_ref_idc, o_unit_type, o_payload_len, o_oversize,
                              o_stream_final};
                check_unit(seen_unit);
            end
            if (cfg_valid && o_cfg_ready) payload_limit = cfg_data;
        end
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if ($urandom_range(99, 0) < stall_pct) begin
                out_stall = 1'b1;
                repeat ($urandom_range(14, 1)) @(negedge i_clk);
                out_stall = 1'b0;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eos, input logic typed,
                             input t_unit_rec u);
        int gap;
        gap = ($urandom_range(99, 0) < gap_pct) ? $urandom_range(14, 1) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_byte = b;
        in_eos = eos;
        in_typed = typed;
        in_typed_unit = u;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic settle_idle();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (pending_units.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_data = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(9, 0);
        if (r < 4) return BYTE_ZERO;
        if (r == 4) return BYTE_ONE;
        if (r == 5) return 8'h03;
        return 8'($urandom_range(255, 0));
    endfunction

    task automatic send_stream(output int count);
        int n;
        int zeros;
        stream_bytes.delete();
        if ($urandom_range(9, 0) == 0) begin
            n = $urandom_range(30, 1);
            repeat (n) stream_bytes.push_back(pick_byte());
        end else begin
            if ($urandom_range(3, 0) == 0) begin
                n = $urandom_range(3, 1);
                repeat (n) stream_bytes.push_back(pick_byte());
            end
            repeat ($urandom_range(5, 1)) begin
                zeros = ($urandom_range(4, 0) == 0) ? $urandom_range(6, 3) : $urandom_range(3, 2);
                repeat (zeros) stream_bytes.push_back(BYTE_ZERO);
                stream_bytes.push_back(BYTE_ONE);
                stream_bytes.push_back(($urandom_range(7, 0) == 0) ? BYTE_ZERO
                                       : 8'($urandom_range(255, 0)));
                n = ($urandom_range(15, 0) == 0) ? $urandom_range(200, 20) : $urandom_range(12, 0);
                repeat (n) stream_bytes.push_back(pick_byte());
            end
            case ($urandom_range(3, 0))
                1: begin
                    repeat ($urandom_range(4, 1)) stream_bytes.push_back(BYTE_ZERO);
                end
                2: begin
                    stream_bytes.push_back(BYTE_ZERO);
                    stream_bytes.push_back(BYTE_ZERO);
                    stream_bytes.push_back(BYTE_ONE);
                end
                3: begin
                    repeat (3) stream_bytes.push_back(BYTE_ZERO);
                    stream_bytes.push_back(BYTE_ONE);
                end
                default: ;
            endcase
        end
        count = stream_bytes.size();
        for (int i = 0; i < count; i++) begin
            send_byte(stream_bytes[i], i == count - 1, 1'b0, NO_UNIT);
        end
    endtask

    initial begin
        int sent;
        int n;
        directed_rows[0]  = '{8'h55, 1'b0, 1'b0, NO_UNIT};
        directed_rows[1]  = '{8'h00, 1'b0, 1'b0, NO_UNIT};
        directed_rows[2]  = '{8'h00, 1'b0, 1'b0, NO_UNIT};
        directed_rows[3]  = '{8'h01, 1'b0, 1'b0, NO_UNIT};
        directed_rows[4]  = '{8'hFF, 1'b0, 1'b0, NO_UNIT};
        directed_rows[5]  = '{8'h00, 1'b0, 1'b0, NO_UNIT};
        directed_rows[6]  = '{8'h00, 1'b0, 1'b0, NO_UNIT};
        directed_rows[7]  = '{8'h00, 1'b0, 1'b0, NO_UNIT};
        directed_rows[8]  = '{8'h00, 1'b0, 1'b0, NO_UNIT};
        directed_rows[9]  = '{8'h01, 1'b0, 1'b1, typed_unit(0, 1, SC_LEN3, 8'hFF, 2, 1'b0)};
        directed_rows[10] = '{8'h00, 1'b0, 1'b0, NO_UNIT};
        directed_rows[11] = '{8'h00, 1'b0, 1'b0, NO_UNIT};
        directed_rows[12] = '{8'h01, 1'b0, 1'b1, typed_unit(1, 6, SC_LEN4, 8'h00, 0, 1'b0)};
        directed_rows[13] = '{8'h01, 1'b0, 1'b0, NO_UNIT};
        directed_rows[14] = '{8'h80, 1'b0, 1'b0, NO_UNIT};
        directed_rows[15] = '{8'h00, 1'b0, 1'b0, NO_UNIT};
        directed_rows[16] = '{8'h00, 1'b1, 1'b1, typed_unit(2, 10, SC_LEN3, 8'h01, 4, 1'b1)};
        directed_rows[17] = '{8'h00, 1'b0, 1'b0, NO_UNIT};
        directed_rows[18] = '{8'h00, 1'b0, 1'b0, NO_UNIT};
        directed_rows[19] = '{8'h01, 1'b0, 1'b0, NO_UNIT};
        directed_rows[20] = '{8'h00, 1'b0, 1'b0, NO_UNIT};
        directed_rows[21] = '{8'h00, 1'b0, 1'b0, NO_UNIT};
        directed_rows[22] = '{8'h01, 1'b1, 1'b1, typed_unit(0, 0, SC_LEN3, 8'h00, 0, 1'b1)};
        directed_rows[23] = '{8'h42, 1'b1, 1'b0, NO_UNIT};
        phase_limits = '{24'hFF_FFFF, 24'd0, 24'd1, 24'd4, 24'($urandom_range(24'hFF_FFFF, 1)),
                         24'($urandom_range(40, 2)), MAX_LEN_RESET};

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        gap_pct = 15;
        stall_pct = 10;
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_byte(directed_rows[i].data, directed_rows[i].eos, directed_rows[i].typed,
                      directed_rows[i].unit);
        end
        settle_idle();

        for (int p = 0; p < N_PHASES; p++) begin
            write_limit(phase_limits[p]);
            if (p == N_PHASES - 1) begin
                gap_pct = 0;
                stall_pct = 0;
            end else begin
                gap_pct = $urandom_range(3, 0) * 6;
                stall_pct = $urandom_range(3, 0) * 6;
            end
            sent = 0;
            while (sent < PHASE_BYTES) begin
                send_stream(n);
                sent += n;
            end
            settle_idle();
        end

        if (mismatches == 0 && pending_units.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[files.f]
src/h264nal_pkg.sv
src/h264nal_front.sv
src/h264nal_fifo.sv
src/h264nal_back.sv
src/h264_nal_unit_splitter.sv
src/h264nal_checker.sv
tb/sv/h264_nal_unit_splitter_test.sv
